// ----- rtl/gcf_pkg.sv -----
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types and codes of the grayscale convolution filter.
// ----------------------------------------------------------------------------
package gcf_pkg;

	localparam logic OP_COEF  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [1:0] REG_DIVISOR      = 2'd0;
	localparam logic [1:0] REG_KERNEL_SIZE  = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	localparam int unsigned MAX_HEIGHT = 4096;

	typedef struct packed {
		logic               op;
		logic [6:0]         coef_index;
		logic signed [15:0] coef_value;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} in_word_t;

	typedef struct packed {
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic [7:0]  out_value;
		logic        was_filtered;
		logic        last_of_run;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_WAIT,
		S_DIV,
		S_RES1,
		S_RES2
	} state_t;

endpackage

// ----- rtl/gray_convolution_filter.sv -----
// ----------------------------------------------------------------------------
// gray_convolution_filter
// RGB to gray, line stores and n x n convolution with divide and clamp.
// ----------------------------------------------------------------------------
//  channel | signals                           | word
//  in      | in_valid, in_ready, in_data       | coefficient write or RGB pixel
//  out     | out_valid, out_ready, out_data    | row, column, gray level, flags
//  cfg     | cfg_we, cfg_index, cfg_data       | register write, no wait
//
// A coefficient write, or a pixel with no result, returns straight to idle. A
// border-only pixel emits its gray level. An interior window makes one line
// store read per window tap, then runs the SW-cell divider chain (SW = 32 at
// the default sizes); a pixel that is also border emits its gray level next.
// Each result waits for a free output register. One word is in work at a
// time; the output register lets the next word in while a result waits. Reset
// clears counters and control only; the stores need writing before use.
module gray_convolution_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_KERNEL = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gcf_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output gcf_pkg::out_word_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	import gcf_pkg::*;

	localparam int KK  = MAX_KERNEL * MAX_KERNEL;
	localparam int KAW = (KK > 1) ? $clog2(KK) : 1;
	localparam int LD  = MAX_KERNEL * MAX_WIDTH;
	localparam int LAW = $clog2(LD);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int NW  = $clog2(MAX_KERNEL + 1);
	localparam int SW  = 25 + $clog2(KK + 1);

	// configuration
	logic [15:0] divisor_q;
	logic [3:0]  ksize_q;
	logic [10:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= 16'd1;
			ksize_q   <= 4'd3;
			width_q   <= 11'd1024;
			height_q  <= 13'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVISOR:      divisor_q <= cfg_data;
				REG_KERNEL_SIZE:  ksize_q   <= cfg_data[3:0];
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data[12:0];
				default:          divisor_q <= divisor_q;
			endcase
		end
	end

	logic [12:0]   eff_w;
	logic [12:0]   eff_h;
	logic [NW-1:0] eff_n;
	logic [NW-1:0] two_b;
	logic [NW-1:0] half_b;
	logic [15:0]   eff_d;

	always_comb begin
		eff_w = (width_q == 11'd0) ? 13'd1 : 13'(width_q);
		if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
		eff_h = (height_q == 13'd0) ? 13'd1 : height_q;
		if (eff_h > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
		if (5'(ksize_q) > 5'(MAX_KERNEL)) eff_n = NW'(MAX_KERNEL);
		else eff_n = NW'(ksize_q);
		if (eff_n == '0) eff_n = NW'(1);
		if (!eff_n[0]) eff_n = eff_n - NW'(1);
		two_b  = eff_n - NW'(1);
		half_b = eff_n >> 1;
		eff_d  = (divisor_q == 16'd0) ? 16'd1 : divisor_q;
	end

	// FSM
	state_t state_q, state_d;
	logic   in_acc, pix_acc, coef_acc;
	logic   issue, last_tap, div_go, out_free, ld1, ld2;
	logic   interior, border, border_q;
	logic   v_s1, v_s2;
	logic   chain_v;

	assign in_acc   = in_valid && in_ready;
	assign pix_acc  = in_acc && (in_data.op == OP_PIXEL);
	assign coef_acc = in_acc && (in_data.op == OP_COEF);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pix_acc && interior) state_d = S_MAC;
				else if (pix_acc && border) state_d = S_RES2;
			end
			S_MAC:  if (last_tap) state_d = S_WAIT;
			S_WAIT: if (div_go) state_d = S_DIV;
			S_DIV:  if (chain_v) state_d = S_RES1;
			S_RES1: if (ld1) state_d = border_q ? S_RES2 : S_IDLE;
			S_RES2: if (ld2) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		div_go   = 1'b0;
		ld1      = 1'b0;
		ld2      = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_MAC:  issue    = 1'b1;
			S_WAIT: div_go   = !v_s1 && !v_s2;
			S_RES1: ld1      = out_free;
			S_RES2: ld2      = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// raster position
	logic [11:0]   row_q;
	logic [CW-1:0] col_q;
	logic [NW-1:0] slot_q;
	logic [12:0]   rr, rr_inc, nr;
	logic [12:0]   cc, nc;
	logic [NW-1:0] sa, sa_inc, ns;

	function automatic logic [NW-1:0] slot_next(input logic [NW-1:0] s);
		slot_next = (s == NW'(MAX_KERNEL - 1)) ? '0 : s + NW'(1);
	endfunction

	always_comb begin
		rr = 13'(row_q);
		cc = 13'(col_q);
		sa = slot_q;
		// wrap on arrival if the frame size shrank
		if (cc >= eff_w) begin
			cc = '0;
			rr = rr + 13'd1;
			sa = slot_next(sa);
		end
		if (rr >= eff_h) begin
			rr = '0;
			sa = '0;
		end
		interior = (rr >= 13'(two_b)) && (cc >= 13'(two_b));
		border   = (rr < 13'(half_b)) || (cc < 13'(half_b)) ||
		           (rr + 13'(half_b) >= eff_h) || (cc + 13'(half_b) >= eff_w);
		nc     = cc + 13'd1;
		nr     = rr;
		ns     = sa;
		rr_inc = rr + 13'd1;
		sa_inc = slot_next(sa);
		if (nc >= eff_w) begin
			nc = '0;
			nr = rr_inc;
			ns = sa_inc;
			if (rr_inc >= eff_h) begin
				nr = '0;
				ns = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (pix_acc) begin
			row_q  <= nr[11:0];
			col_q  <= nc[CW-1:0];
			slot_q <= ns;
		end
	end

	// gray level: divide by 3 through a reciprocal multiply
	logic [9:0]  rgb_sum;
	logic [19:0] rgb_scaled;
	logic [7:0]  gray;

	assign rgb_sum    = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
	assign rgb_scaled = 20'(rgb_sum) * 20'd683;
	assign gray       = rgb_scaled[18:11];

	// result context
	logic [11:0] brow_q, frow_q;
	logic [9:0]  bcol_q, fcol_q;
	logic [7:0]  gray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= 1'b0;
		end else if (pix_acc) begin
			border_q <= border;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			brow_q <= rr[11:0];
			bcol_q <= 10'(cc);
			frow_q <= 12'(rr - 13'(half_b));
			fcol_q <= 10'(cc - 13'(half_b));
			gray_q <= gray;
		end
	end

	// window walk
	logic [NW-1:0]  wk_q, wl_q, wslot_q;
	logic [12:0]    wcol_q, col0_q;
	logic [KAW-1:0] kidx_q;
	logic [NW-1:0]  slot_start;

	assign slot_start = (sa >= two_b) ? sa - two_b : NW'(5'(sa) + 5'(MAX_KERNEL) - 5'(two_b));
	assign last_tap   = issue && (wk_q == two_b) && (wl_q == two_b);

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			wk_q    <= '0;
			wl_q    <= '0;
			wslot_q <= slot_start;
			wcol_q  <= cc - 13'(two_b);
			col0_q  <= cc - 13'(two_b);
			kidx_q  <= '0;
		end else if (issue) begin
			if (wl_q == two_b) begin
				// advance to the next window row
				wl_q    <= '0;
				wk_q    <= wk_q + NW'(1);
				wslot_q <= slot_next(wslot_q);
				wcol_q  <= col0_q;
				kidx_q  <= KAW'(kidx_q + KAW'(MAX_KERNEL) - KAW'(two_b));
			end else begin
				wl_q   <= wl_q + NW'(1);
				wcol_q <= wcol_q + 13'd1;
				kidx_q <= kidx_q + KAW'(1);
			end
		end
	end

	// stores
	logic [LAW-1:0] ls_waddr, ls_raddr;
	logic [7:0]     ls_rdata;
	logic [15:0]    k_rdata;
	logic           k_we;

	assign ls_waddr = LAW'(LAW'(sa) * LAW'(MAX_WIDTH)) + LAW'(cc);
	assign ls_raddr = LAW'(LAW'(wslot_q) * LAW'(MAX_WIDTH)) + LAW'(wcol_q);
	assign k_we     = coef_acc && (8'(in_data.coef_index) < 8'(KK));

	gcf_ram #(.WIDTH(8), .DEPTH(LD), .AW(LAW)) u_line_store (
		.clk  (clk),
		.we   (pix_acc),
		.waddr(ls_waddr),
		.wdata(gray),
		.raddr(ls_raddr),
		.rdata(ls_rdata)
	);

	gcf_ram #(.WIDTH(16), .DEPTH(KK), .AW(KAW)) u_kernel_store (
		.clk  (clk),
		.we   (k_we),
		.waddr(KAW'(in_data.coef_index)),
		.wdata(in_data.coef_value),
		.raddr(kidx_q),
		.rdata(k_rdata)
	);

	// multiply and accumulate
	logic signed [24:0]   prod_s2;
	logic signed [SW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) prod_s2 <= $signed({1'b0, ls_rdata}) * $signed(k_rdata);
		if (pix_acc) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + SW'(prod_s2);
	end

	// divider chain
	logic          cv   [SW+1];
	logic          cneg [SW+1];
	logic [15:0]   crem [SW+1];
	logic [SW-1:0] cnum [SW+1];
	logic [SW-1:0] cquo [SW+1];
	logic [15:0]   cden [SW+1];

	assign cv[0]   = div_go;
	assign cneg[0] = acc_q[SW-1];
	assign crem[0] = '0;
	assign cnum[0] = acc_q[SW-1] ? SW'(-acc_q) : SW'(acc_q);
	assign cquo[0] = '0;
	assign cden[0] = eff_d;

	for (genvar i = 0; i < SW; i++) begin : g_cell
		gcf_div_cell #(.SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (cv[i]),
			.neg_in (cneg[i]),
			.rem_in (crem[i]),
			.num_in (cnum[i]),
			.quo_in (cquo[i]),
			.den_in (cden[i]),
			.v_out  (cv[i+1]),
			.neg_out(cneg[i+1]),
			.rem_out(crem[i+1]),
			.num_out(cnum[i+1]),
			.quo_out(cquo[i+1]),
			.den_out(cden[i+1])
		);
	end

	assign chain_v = cv[SW];

	// clamp: a negative quotient gives zero, one above 255 gives 255
	logic [7:0] res_q;

	always_ff @(posedge clk) begin
		if (chain_v) begin
			if (cneg[SW]) res_q <= 8'd0;
			else if (cquo[SW] > SW'(255)) res_q <= 8'd255;
			else res_q <= cquo[SW][7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld1 || ld2) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			out_data.out_row      <= frow_q;
			out_data.out_col      <= fcol_q;
			out_data.out_value    <= res_q;
			out_data.was_filtered <= 1'b1;
			out_data.last_of_run  <= !border_q;
		end else if (ld2) begin
			out_data.out_row      <= brow_q;
			out_data.out_col      <= bcol_q;
			out_data.out_value    <= gray_q;
			out_data.was_filtered <= 1'b0;
			out_data.last_of_run  <= 1'b1;
		end
	end

endmodule

// ----- rtl/gcf_ram.sv -----
// ----------------------------------------------------------------------------
// gcf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/gcf_div_cell.sv -----
// ----------------------------------------------------------------------------
// gcf_div_cell
// One step of a restoring divider; resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module gcf_div_cell #(
	parameter int SW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  logic          neg_in,
	input  logic [15:0]   rem_in,
	input  logic [SW-1:0] num_in,
	input  logic [SW-1:0] quo_in,
	input  logic [15:0]   den_in,
	output logic          v_out,
	output logic          neg_out,
	output logic [15:0]   rem_out,
	output logic [SW-1:0] num_out,
	output logic [SW-1:0] quo_out,
	output logic [15:0]   den_out
);

	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_in, num_in[SW-1]};
	assign fits  = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		neg_out <= neg_in;
		den_out <= den_in;
		num_out <= {num_in[SW-2:0], 1'b0};
		quo_out <= {quo_in[SW-2:0], fits};
		// remainder stays below the divisor, so 16 bits hold it
		rem_out <= fits ? 16'(trial - {1'b0, den_in}) : trial[15:0];
	end

endmodule
